// ----- rtl/cbc_pkg.sv -----
// Package for the colour blob centroid block: sizes, payload types and state codes.
`default_nettype none

package cbc_pkg;

    // Largest frame that the accumulators must cover without overflow.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MATCH_CAP  = MAX_WIDTH * MAX_HEIGHT;

    localparam int CHAN_W   = 8;
    localparam int COORD_W  = 10;
    localparam int FACTOR_W = 4;
    localparam int PROD_W   = CHAN_W + FACTOR_W;
    localparam int CNT_W    = $clog2(MATCH_CAP + 1);
    localparam int SUM_W    = COORD_W + $clog2(MATCH_CAP);

    localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(5);

    // The mean of coordinates fits a coordinate, so the quotient has COORD_W bits.
    localparam int QUOT_W = COORD_W;
    localparam int DIV_W  = CNT_W + QUOT_W;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0] col_sum;
        logic [SUM_W-1:0] row_sum;
        logic [CNT_W-1:0] count;
    } t_frame_sums;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } t_back_state;

endpackage

`default_nettype wire

// ----- rtl/cbc_ifs.sv -----
// Channel interfaces of the colour blob centroid block: pixel items in, result items out.
`default_nettype none

interface cbc_pixel_if
    import cbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  pixel_red;
    logic [CHAN_W-1:0]  pixel_green;
    logic [CHAN_W-1:0]  pixel_blue;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               frame_end;

    modport source (output valid, pixel_red, pixel_green, pixel_blue, column, row, frame_end,
                    input ready);
    modport sink   (input valid, pixel_red, pixel_green, pixel_blue, column, row, frame_end,
                    output ready);
endinterface

interface cbc_result_if
    import cbc_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               found;
    logic [COORD_W-1:0] centroid_column;
    logic [COORD_W-1:0] centroid_row;

    modport source (output valid, found, centroid_column, centroid_row, input ready);
    modport sink   (input valid, found, centroid_column, centroid_row, output ready);
endinterface

`default_nettype wire

// ----- rtl/cbc_front.sv -----
// Front end: colour test of each pixel item and the per-frame column, row and count sums.
`default_nettype none

module cbc_front
    import cbc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [FACTOR_W-1:0] i_cfg_wdata,
    cbc_pixel_if.sink                i_pixel,
    input  wire logic                i_q_full,
    output logic                     o_push,
    output t_frame_sums              o_push_data
);

    logic [FACTOR_W-1:0] r_factor;
    logic [SUM_W-1:0]    r_col_sum;
    logic [SUM_W-1:0]    r_row_sum;
    logic [CNT_W-1:0]    r_count;

    logic [PROD_W-1:0] prod_red;
    logic [PROD_W-1:0] prod_green;
    logic              match;
    logic              take;
    logic              accept;
    t_frame_sums       n_sums;

    assign i_pixel.ready = !i_q_full;
    assign accept        = i_pixel.valid && i_pixel.ready;

    assign prod_red   = PROD_W'(r_factor) * PROD_W'(i_pixel.pixel_red);
    assign prod_green = PROD_W'(r_factor) * PROD_W'(i_pixel.pixel_green);
    assign match      = (PROD_W'(i_pixel.pixel_blue) > prod_red)
                     && (PROD_W'(i_pixel.pixel_blue) > prod_green);
    // Matches beyond the largest frame are dropped so the sums never wrap.
    assign take       = match && (r_count < CNT_W'(MATCH_CAP));

    always_comb begin
        n_sums.col_sum = r_col_sum;
        n_sums.row_sum = r_row_sum;
        n_sums.count   = r_count;
        if (take) begin
            n_sums.col_sum = r_col_sum + SUM_W'(i_pixel.column);
            n_sums.row_sum = r_row_sum + SUM_W'(i_pixel.row);
            n_sums.count   = r_count + CNT_W'(1);
        end
    end

    assign o_push      = accept && i_pixel.frame_end;
    assign o_push_data = n_sums;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor  <= FACTOR_RESET;
            r_col_sum <= '0;
            r_row_sum <= '0;
            r_count   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_factor <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_pixel.frame_end) begin
                    r_col_sum <= '0;
                    r_row_sum <= '0;
                    r_count   <= '0;
                end else begin
                    r_col_sum <= n_sums.col_sum;
                    r_row_sum <= n_sums.row_sum;
                    r_count   <= n_sums.count;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cbc_queue.sv -----
// Short queue of finished frame sums between the front end and the divider.
`default_nettype none

module cbc_queue
    import cbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire t_frame_sums i_push_data,
    output logic             o_full,
    output logic             o_valid,
    input  wire logic        i_pop,
    output t_frame_sums      o_data
);

    t_frame_sums          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + Q_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - Q_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cbc_back.sv -----
// Back end: restoring divider for both means, one quotient bit a cycle, and the result register.
`default_nettype none

module cbc_back
    import cbc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_q_valid,
    input  wire t_frame_sums i_q_data,
    output logic             o_q_pop,
    cbc_result_if.source     o_result
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [DIV_W-1:0]   r_rem_col;
    logic [DIV_W-1:0]   r_rem_row;
    logic [DIV_W-1:0]   r_div;
    logic [QUOT_W-1:0]  r_q_col;
    logic [QUOT_W-1:0]  r_q_row;
    logic [STEP_W-1:0]  r_step;
    logic               r_nonzero;

    logic               r_out_valid;
    logic               r_out_found;
    logic [COORD_W-1:0] r_out_col;
    logic [COORD_W-1:0] r_out_row;

    logic               ge_col;
    logic               ge_row;
    logic               load_out;

    assign ge_col   = (r_rem_col >= r_div);
    assign ge_row   = (r_rem_row >= r_div);
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid;
    assign load_out = (r_state == ST_HOLD) && (!r_out_valid || o_result.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_q_valid) begin
                n_state = ST_DIV;
            end
            ST_DIV: if (r_step == '0) begin
                n_state = ST_HOLD;
            end
            ST_HOLD: if (load_out) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rem_col <= DIV_W'(i_q_data.col_sum);
            r_rem_row <= DIV_W'(i_q_data.row_sum);
            r_div     <= DIV_W'(i_q_data.count) << (QUOT_W - 1);
            r_nonzero <= (i_q_data.count != '0);
            r_step    <= STEP_W'(QUOT_W - 1);
        end else if (r_state == ST_DIV) begin
            if (ge_col) begin
                r_rem_col <= r_rem_col - r_div;
            end
            if (ge_row) begin
                r_rem_row <= r_rem_row - r_div;
            end
            r_q_col <= {r_q_col[QUOT_W-2:0], ge_col};
            r_q_row <= {r_q_row[QUOT_W-2:0], ge_row};
            r_div   <= r_div >> 1;
            r_step  <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An empty frame divides by zero; the quotient is then replaced by zero.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_found <= r_nonzero;
            r_out_col   <= r_nonzero ? r_q_col : '0;
            r_out_row   <= r_nonzero ? r_q_row : '0;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.found           = r_out_found;
    assign o_result.centroid_column = r_out_col;
    assign o_result.centroid_row    = r_out_row;

endmodule

`default_nettype wire

// ----- rtl/color_blob_centroid.sv -----
// Pixel items are taken one per cycle while the two-entry queue has room; new sums are
// popped only once the result register has been loaded, and the divider forms one
// quotient bit of both means per cycle. Frames that close faster than the back end
// finishes them, or a stalled result, fill the queue and hold pixel items off. Reset
// (i_rst_n low at a clock edge, synchronous) clears the sums, the queue and the result
// valid flag, and sets the dominance factor to 5.
`default_nettype none

// Top level of the colour blob centroid block.
//
// The front end tests every pixel item against the dominance factor and keeps
// running column, row and match sums for the current frame. On the pixel that
// closes a frame it pushes the finished sums into a two-entry queue and starts
// the next frame from zero in the same cycle, so a division in progress does
// not stop the pixel stream by itself. Pixel items are held off only while
// the queue is full.
//
// The back end pops one set of sums at a time and runs a restoring division of
// the column sum and the row sum by the match count in parallel, one quotient
// bit per cycle. The result then waits in an output register until it is
// taken; the next set of sums is not popped until that register has been
// loaded.
//
// The dominance factor is written through i_cfg_we and i_cfg_wdata and applies
// from the next pixel item onwards.
module color_blob_centroid
    import cbc_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [FACTOR_W-1:0] i_cfg_wdata,
    cbc_pixel_if.sink                i_pixel,
    cbc_result_if.source             o_result
);

    logic        q_full;
    logic        q_push;
    t_frame_sums q_push_data;
    logic        q_valid;
    logic        q_pop;
    t_frame_sums q_data;

    cbc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pixel     (i_pixel),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    cbc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .i_pop       (q_pop),
        .o_data      (q_data)
    );

    cbc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

`default_nettype wire

// ----- rtl/cbc_checker.sv -----
// Port-level checker for the colour blob centroid block and its bind to the top level.
`default_nettype none

module cbc_checker
    import cbc_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic               i_found,
    input wire logic [COORD_W-1:0] i_centroid_column,
    input wire logic [COORD_W-1:0] i_centroid_row
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_found) |-> (i_centroid_column == '0 && i_centroid_row == '0))
        else $error("empty frame gave a nonzero centroid");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped while stalled");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            ($stable(i_found) && $stable(i_centroid_column) && $stable(i_centroid_row)))
        else $error("result changed while stalled");

endmodule

bind color_blob_centroid cbc_checker u_cbc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_found           (o_result.found),
    .i_centroid_column (o_result.centroid_column),
    .i_centroid_row    (o_result.centroid_row)
);

`default_nettype wire

// ----- dv/color_blob_centroid_tb.sv -----
// Self-checking testbench of the colour blob centroid block: directed table, random frames.
module color_blob_centroid_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cbc_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_TICKS  = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 200;
    localparam int DIRECTED_ROWS = 18;

    typedef struct packed {
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } pixel_item_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
    } centroid_t;

    typedef struct packed {
        logic                set_factor;
        logic [FACTOR_W-1:0] factor;
        pixel_item_t         px;
        logic                typed;
        centroid_t           want;
    } directed_row_t;

    // Factors of the first random phases; later phases pick one at random.
    localparam logic [FACTOR_W-1:0] FACTOR_PLAN [4] = '{4'd15, 4'd0, 4'd1, FACTOR_RESET};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [FACTOR_W-1:0] i_cfg_wdata;
    logic                result_ready = 1'b0;
    // A typed-in expectation travels with its pixel item, so it lines up with acceptance.
    logic                typed_on_bus;
    centroid_t           typed_want_on_bus;

    cbc_pixel_if  pix_if ();
    cbc_result_if res_if ();
    assign res_if.ready = result_ready;

    color_blob_centroid uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pixel     (pix_if.sink),
        .o_result    (res_if.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block: factor and running sums of the current frame.
    logic [FACTOR_W-1:0] factor_shadow = FACTOR_RESET;
    logic [SUM_W-1:0]    column_total  = '0;
    logic [SUM_W-1:0]    row_total     = '0;
    logic [CNT_W-1:0]    match_total   = '0;
    centroid_t           expected_centroids [$];

    int mismatches     = 0;
    int pixels_taken   = 0;
    int frames_checked = 0;
    int idle_ticks     = 0;
    int stall_left     = 0;
    bit calm           = 1'b0;

    // Directed rows. Typed expectations only where the answer is obvious.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // Straight after reset: a black pixel alone gives an empty frame.
        '{0, 0, '{0, 0, 0, 0, 0, 1}, 1, '{0, 0, 0}},
        '{0, 0, '{0, 0, 255, 1023, 1023, 1}, 1, '{1, 1023, 1023}},
        '{0, 0, '{0, 0, 255, 0, 0, 1}, 1, '{1, 0, 0}},
        '{0, 0, '{0, 0, 255, 1023, 0, 0}, 0, '0},
        '{0, 0, '{0, 0, 255, 0, 1023, 1}, 0, '0},
        // Around the threshold at factor 5: equality does not match.
        '{0, 0, '{51, 0, 255, 100, 200, 0}, 0, '0},
        '{0, 0, '{50, 50, 255, 300, 400, 0}, 0, '0},
        '{0, 0, '{0, 51, 255, 700, 800, 1}, 0, '0},
        '{0, 0, '{255, 255, 255, 1023, 1023, 1}, 1, '{0, 0, 0}},
        // Zero factor: any non-zero blue matches.
        '{1, 0, '{255, 255, 1, 512, 256, 0}, 0, '0},
        '{0, 0, '{255, 255, 0, 5, 5, 1}, 0, '0},
        // Largest factor.
        '{1, 15, '{17, 17, 255, 10, 20, 0}, 0, '0},
        '{0, 15, '{16, 16, 255, 30, 40, 0}, 0, '0},
        '{0, 15, '{0, 0, 15, 1, 1, 1}, 0, '0},
        // Unit factor: blue just has to be the largest channel.
        '{1, 1, '{254, 0, 255, 1023, 0, 0}, 0, '0},
        '{0, 1, '{0, 255, 255, 600, 600, 0}, 0, '0},
        '{0, 1, '{128, 128, 129, 0, 1023, 1}, 0, '0},
        '{1, 5, '{0, 0, 1, 1, 1, 1}, 0, '0}
    };

    // Folds one pixel into the shadow sums; on the frame's last pixel it gives the means.
    function automatic logic absorb_pixel(input pixel_item_t px, output centroid_t mean);
        logic [PROD_W-1:0] red_bar;
        logic [PROD_W-1:0] green_bar;
        logic [SUM_W-1:0]  col_q;
        logic [SUM_W-1:0]  row_q;
        red_bar   = PROD_W'(factor_shadow) * PROD_W'(px.red);
        green_bar = PROD_W'(factor_shadow) * PROD_W'(px.green);
        // Matches beyond the cap are dropped, so the sums never overflow.
        if (PROD_W'(px.blue) > red_bar && PROD_W'(px.blue) > green_bar &&
            match_total < CNT_W'(MATCH_CAP)) begin
            column_total += SUM_W'(px.column);
            row_total    += SUM_W'(px.row);
            match_total  += 1'b1;
        end
        mean = '0;
        if (px.frame_end) begin
            if (match_total != 0) begin
                col_q       = column_total / SUM_W'(match_total);
                row_q       = row_total / SUM_W'(match_total);
                mean.found  = 1'b1;
                mean.column = col_q[COORD_W-1:0];
                mean.row    = row_q[COORD_W-1:0];
            end
            column_total = '0;
            row_total    = '0;
            match_total  = '0;
        end
        return px.frame_end;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // Receiver side: random bursts of stalled cycles, none while calm.
    always @(posedge i_clk) begin
        if (calm) begin
            result_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            result_ready <= 1'b0;
        end else begin
            result_ready <= 1'b1;
        end
    end

    // Acceptance monitor: predicts on every pixel item, checks every result item.
    always @(posedge i_clk) begin
        pixel_item_t seen;
        centroid_t   mean;
        centroid_t   got;
        centroid_t   want;
        logic        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (pix_if.valid && pix_if.ready) begin
                moved = 1'b1;
                pixels_taken++;
                seen = {pix_if.pixel_red, pix_if.pixel_green, pix_if.pixel_blue,
                        pix_if.column, pix_if.row, pix_if.frame_end};
                if (absorb_pixel(seen, mean))
                    expected_centroids.push_back(typed_on_bus ? typed_want_on_bus : mean);
            end
            if (res_if.valid && result_ready) begin
                moved = 1'b1;
                got = {res_if.found, res_if.centroid_column, res_if.centroid_row};
                if (expected_centroids.size() == 0) begin
                    flag_mismatch($sformatf("result %0d came with none expected",
                                            frames_checked));
                end else begin
                    want = expected_centroids.pop_front();
                    if (got.found !== want.found)
                        flag_mismatch($sformatf("frame %0d found %0b, expected %0b",
                                                frames_checked, got.found, want.found));
                    if (got.column !== want.column)
                        flag_mismatch($sformatf("frame %0d column %0d, expected %0d",
                                                frames_checked, got.column, want.column));
                    if (got.row !== want.row)
                        flag_mismatch($sformatf("frame %0d row %0d, expected %0d",
                                                frames_checked, got.row, want.row));
                end
                frames_checked++;
            end
            idle_ticks = moved ? 0 : idle_ticks + 1;
            if (idle_ticks >= IDLE_LIMIT) begin
                $display("Watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Presents one pixel item, with an occasional gap first, and holds it until taken.
    task automatic send_pixel(input pixel_item_t px, input logic typed, input centroid_t want);
        int gap;
        gap = (!calm && $urandom_range(0, 6) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        {pix_if.pixel_red, pix_if.pixel_green, pix_if.pixel_blue,
         pix_if.column, pix_if.row, pix_if.frame_end} <= px;
        typed_on_bus      <= typed;
        typed_want_on_bus <= want;
        do @(posedge i_clk); while (!pix_if.ready);
    endtask

    // Stops sending until every expected result is in, then lets the pipeline settle.
    task automatic drain_results;
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_centroids.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic load_factor(input logic [FACTOR_W-1:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        factor_shadow = value;
    endtask

    initial begin
        pixel_item_t px;
        int          frame_len;
        int          shape;
        int          limit;
        int          blue_level;
        int          used;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        pix_if.valid      <= 1'b0;
        {pix_if.pixel_red, pix_if.pixel_green, pix_if.pixel_blue,
         pix_if.column, pix_if.row, pix_if.frame_end} <= '0;
        typed_on_bus      <= 1'b0;
        typed_want_on_bus <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_factor)
                load_factor(directed_rows[i].factor);
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random frames, mostly short, with a fresh factor for every phase.
        for (int phase = 0; phase < PHASES; phase++) begin
            load_factor(phase < 4 ? FACTOR_PLAN[phase] : FACTOR_W'($urandom_range(0, 15)));
            calm = (phase == 3 || phase == PHASES - 1);
            used = 0;
            while (used < PHASE_ITEMS) begin
                frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                                        : $urandom_range(1, 8);
                for (int k = 0; k < frame_len; k++) begin
                    shape      = $urandom_range(0, 9);
                    blue_level = $urandom_range(0, 255);
                    // Largest red or green that still lets this blue match.
                    if (factor_shadow == 0)
                        limit = 255;
                    else
                        limit = (blue_level == 0) ? 0 : (blue_level - 1) / int'(factor_shadow);
                    px.blue = CHAN_W'(blue_level);
                    if (shape < 2) begin
                        px.red   = CHAN_W'($urandom);
                        px.green = CHAN_W'($urandom);
                    end else if (shape < 7) begin
                        px.red   = CHAN_W'($urandom_range(0, limit));
                        px.green = CHAN_W'($urandom_range(0, limit));
                    end else begin
                        px.red   = CHAN_W'(limit + $urandom_range(0, 1));
                        px.green = CHAN_W'(limit + $urandom_range(0, 1));
                    end
                    px.column    = COORD_W'($urandom_range(0, 1023));
                    px.row       = COORD_W'($urandom_range(0, 1023));
                    px.frame_end = (k == frame_len - 1);
                    send_pixel(px, 1'b0, '0);
                    used++;
                end
                if ($urandom_range(0, 19) == 0)
                    drain_results();
            end
        end

        drain_results();
        $display("Run covered %0d pixel items and %0d frame results,", pixels_taken,
                 frames_checked);
        $display("factors from 0 to 15, thresholds, empty frames and stalled results.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
